// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/msc_pkg.sv -----
// ----------------------------------------------------------------------------
// Minimum set cover package
// Request and result types, sequencer states and shared constants.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int unsigned MaxSkillsDef = 16;
  localparam int unsigned MaxCandDef   = 64;

  localparam int unsigned MaskW     = 16;  // width of one candidate mask
  localparam int unsigned SkillCntW = 5;   // width of the skill count register
  localparam int unsigned CountW    = 5;   // width of one cover count entry
  localparam int unsigned IndexBits = 6;   // candidate field of a back pointer

  localparam logic [SkillCntW-1:0] SkillCntRst = SkillCntW'(16);
  localparam logic [CountW-1:0]    Unreached   = CountW'(31);

  typedef struct packed {
    logic [MaskW-1:0] skill_mask;
    logic             last_candidate;
  } in_req_t;

  typedef struct packed {
    logic [IndexBits-1:0] member_index;
    logic                 no_cover;
    logic                 last_member;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CAND,
    ST_CWAIT,
    ST_RD_M,
    ST_CHK_M,
    ST_UPD,
    ST_FIN,
    ST_FCHK,
    ST_TB_RD,
    ST_TB_WT,
    ST_EMIT
  } msc_state_e;

endpackage

// ----- hw/rtl/minimum_set_cover_bitmask.sv -----
// ----------------------------------------------------------------------------
// Minimum set cover over skill bitmasks
// Loads candidate skill masks, then finds and emits a smallest covering team.
// ----------------------------------------------------------------------------
// Each accepted request loads one candidate mask while the candidate store has
// room; a request beyond MAX_CANDIDATES is dropped. The request carrying
// last_candidate starts the search, and no further request is taken until the
// final result of the team has been loaded into the output register. With
// F = 2^n, n being the clamped skill count, the search first clears all F
// entries of the cover count table, then reads each loaded candidate in turn
// and, for every candidate whose mask has a required skill, makes one pass
// over all F table entries, skipping an entry that is unreachable or gains
// nothing and comparing the others against their target. The table memory
// has a single read port. The full mask entry is then checked, the back
// pointers are traced from it member by member, and results are handed out
// as the receiver takes them. Results come out in the reverse order of the back
// pointer trace, which is normally ascending load order; when no team exists
// one result with no_cover set is given instead.
// ----------------------------------------------------------------------------
module minimum_set_cover_bitmask #(
  parameter int unsigned MAX_SKILLS     = msc_pkg::MaxSkillsDef,
  parameter int unsigned MAX_CANDIDATES = msc_pkg::MaxCandDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // candidate requests
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  msc_pkg::in_req_t                in_req_i,
  // team results
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output msc_pkg::out_res_t               out_res_o,
  // skill count register
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [msc_pkg::SkillCntW-1:0]   cfg_data_i
);

  localparam int unsigned SW    = MAX_SKILLS;
  localparam int unsigned TDEP  = 1 << SW;
  localparam int unsigned CIW   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int unsigned CTW   = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned MW    = $clog2(MAX_SKILLS + 1);
  localparam int unsigned KW    = (MAX_SKILLS > 1) ? $clog2(MAX_SKILLS) : 1;
  localparam int unsigned IB    = msc_pkg::IndexBits;
  localparam int unsigned BPW   = SW + IB;
  localparam int unsigned SCW   = msc_pkg::SkillCntW;
  localparam int unsigned CW    = msc_pkg::CountW;

  // Memories: candidate store, cover counts and back pointers
  logic [msc_pkg::MaskW-1:0] cand_mem [MAX_CANDIDATES];
  logic [CW-1:0]             cc_mem   [TDEP];
  logic [BPW-1:0]            bp_mem   [TDEP];

  logic [msc_pkg::MaskW-1:0] cand_rd_q;
  logic [CW-1:0]             cc_rd_q;
  logic [BPW-1:0]            bp_rd_q;

  // Control state
  msc_pkg::msc_state_e state_q, state_d;
  logic [SCW-1:0]      skill_count_q, skill_count_d;
  logic [CTW-1:0]      total_q, total_d;
  logic                out_valid_q, out_valid_d;

  // Working registers
  logic [SW-1:0]       full_q, full_d;
  logic [CTW-1:0]      i_q, i_d;
  logic [SW-1:0]       m_q, m_d;
  logic [SW-1:0]       c_q, c_d;
  logic [CW-1:0]       cm_q, cm_d;
  logic [SW-1:0]       cur_q, cur_d;
  logic [MW-1:0]       cnt_q, cnt_d;
  logic [KW-1:0]       k_q, k_d;
  logic                nocov_q, nocov_d;
  logic [IB-1:0]       members_q [MAX_SKILLS];
  logic [IB-1:0]       members_d [MAX_SKILLS];
  msc_pkg::out_res_t   out_res_q, out_res_d;

  // Memory port controls
  logic                cand_we;
  logic [SW-1:0]       cc_raddr;
  logic                cc_we;
  logic [SW-1:0]       cc_waddr;
  logic [CW-1:0]       cc_wdata;
  logic                bp_we;
  logic [BPW-1:0]      bp_wdata;

  // Derived values
  logic                in_acc;
  logic                out_free;
  logic [SCW-1:0]      n_eff;
  logic [SW-1:0]       full_c;
  logic [SW-1:0]       t_c;
  logic [CW-1:0]       nc_c;
  logic                last_emit;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != msc_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // Clamp the skill count to 1..MAX_SKILLS and build the full cover mask
  always_comb begin
    if (skill_count_q == '0) begin
      n_eff = SCW'(1);
    end else if (skill_count_q > SCW'(MAX_SKILLS)) begin
      n_eff = SCW'(MAX_SKILLS);
    end else begin
      n_eff = skill_count_q;
    end
    for (int b = 0; b < SW; b++) begin
      full_c[b] = (SCW'(b) < n_eff);
    end
  end

  assign t_c       = m_q | c_q;
  assign nc_c      = cm_q + CW'(1);
  assign last_emit = nocov_q || (k_q == '0);

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (cand_we) begin
      cand_mem[total_q[CIW-1:0]] <= in_req_i.skill_mask;
    end
    cand_rd_q <= cand_mem[i_q[CIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cc_we) begin
      cc_mem[cc_waddr] <= cc_wdata;
    end
    cc_rd_q <= cc_mem[cc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[t_c] <= bp_wdata;
    end
    bp_rd_q <= bp_mem[cur_q];
  end

  // Sequencer state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= msc_pkg::ST_IDLE;
      skill_count_q <= msc_pkg::SkillCntRst;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      skill_count_q <= skill_count_d;
      total_q       <= total_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Working registers carry no reset: each is set before it is read
  always_ff @(posedge clk_i) begin
    full_q    <= full_d;
    i_q       <= i_d;
    m_q       <= m_d;
    c_q       <= c_d;
    cm_q      <= cm_d;
    cur_q     <= cur_d;
    cnt_q     <= cnt_d;
    k_q       <= k_d;
    nocov_q   <= nocov_d;
    members_q <= members_d;
    out_res_q <= out_res_d;
  end

  // Next state, datapath and memory controls
  always_comb begin
    state_d       = state_q;
    skill_count_d = cfg_valid_i ? cfg_data_i : skill_count_q;
    total_d       = total_q;
    full_d        = full_q;
    i_d           = i_q;
    m_d           = m_q;
    c_d           = c_q;
    cm_d          = cm_q;
    cur_d         = cur_q;
    cnt_d         = cnt_q;
    k_d           = k_q;
    nocov_d       = nocov_q;
    members_d     = members_q;
    out_res_d     = out_res_q;
    out_valid_d   = out_valid_q && out_stall_i;

    cand_we  = 1'b0;
    cc_raddr = m_q;
    cc_we    = 1'b0;
    cc_waddr = m_q;
    cc_wdata = msc_pkg::Unreached;
    bp_we    = 1'b0;
    bp_wdata = {m_q, IB'(i_q)};

    unique case (state_q)
      msc_pkg::ST_IDLE: begin
        if (in_acc) begin
          // Store the candidate unless the store is full; drop it otherwise
          if (total_q < CTW'(MAX_CANDIDATES)) begin
            cand_we = 1'b1;
            total_d = total_q + CTW'(1);
          end
          if (in_req_i.last_candidate) begin
            full_d  = full_c;
            m_d     = '0;
            state_d = msc_pkg::ST_CLEAR;
          end
        end
      end

      msc_pkg::ST_CLEAR: begin
        // Sweep the count table: empty mask costs nothing, the rest unreachable
        cc_we    = 1'b1;
        cc_waddr = m_q;
        cc_wdata = (m_q == '0) ? '0 : msc_pkg::Unreached;
        if (m_q == full_q) begin
          i_d     = '0;
          state_d = msc_pkg::ST_CAND;
        end else begin
          m_d = m_q + SW'(1);
        end
      end

      msc_pkg::ST_CAND: begin
        // Candidate mask is read at i_q and shows up in the next cycle
        if (i_q == total_q) begin
          state_d = msc_pkg::ST_FIN;
        end else begin
          state_d = msc_pkg::ST_CWAIT;
        end
      end

      msc_pkg::ST_CWAIT: begin
        c_d = SW'(cand_rd_q) & full_q;
        m_d = '0;
        if ((SW'(cand_rd_q) & full_q) == '0) begin
          // No required skill: never chosen
          i_d     = i_q + CTW'(1);
          state_d = msc_pkg::ST_CAND;
        end else begin
          state_d = msc_pkg::ST_RD_M;
        end
      end

      msc_pkg::ST_RD_M: begin
        cc_raddr = m_q;
        state_d  = msc_pkg::ST_CHK_M;
      end

      msc_pkg::ST_CHK_M: begin
        cm_d     = cc_rd_q;
        cc_raddr = t_c;
        if ((cc_rd_q == msc_pkg::Unreached) || (t_c == m_q)) begin
          if (m_q == full_q) begin
            i_d     = i_q + CTW'(1);
            state_d = msc_pkg::ST_CAND;
          end else begin
            m_d     = m_q + SW'(1);
            state_d = msc_pkg::ST_RD_M;
          end
        end else begin
          state_d = msc_pkg::ST_UPD;
        end
      end

      msc_pkg::ST_UPD: begin
        // Take the new team only when strictly smaller
        if (nc_c < cc_rd_q) begin
          cc_we    = 1'b1;
          cc_waddr = t_c;
          cc_wdata = nc_c;
          bp_we    = 1'b1;
        end
        if (m_q == full_q) begin
          i_d     = i_q + CTW'(1);
          state_d = msc_pkg::ST_CAND;
        end else begin
          m_d     = m_q + SW'(1);
          state_d = msc_pkg::ST_RD_M;
        end
      end

      msc_pkg::ST_FIN: begin
        cc_raddr = full_q;
        total_d  = '0;
        state_d  = msc_pkg::ST_FCHK;
      end

      msc_pkg::ST_FCHK: begin
        if (cc_rd_q == msc_pkg::Unreached) begin
          nocov_d = 1'b1;
          state_d = msc_pkg::ST_EMIT;
        end else begin
          nocov_d = 1'b0;
          cur_d   = full_q;
          cnt_d   = '0;
          state_d = msc_pkg::ST_TB_RD;
        end
      end

      msc_pkg::ST_TB_RD: begin
        // Back pointer of cur_q is read here and valid in the next cycle
        if ((cur_q == '0) || (cnt_q == MW'(MAX_SKILLS))) begin
          k_d     = KW'(cnt_q - MW'(1));
          state_d = msc_pkg::ST_EMIT;
        end else begin
          state_d = msc_pkg::ST_TB_WT;
        end
      end

      msc_pkg::ST_TB_WT: begin
        members_d[cnt_q[KW-1:0]] = bp_rd_q[IB-1:0];
        cur_d   = bp_rd_q[BPW-1:IB] & full_q;
        cnt_d   = cnt_q + MW'(1);
        state_d = msc_pkg::ST_TB_RD;
      end

      msc_pkg::ST_EMIT: begin
        // Members were gathered last first; hand them out in reverse
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_res_d.member_index = nocov_q ? '0 : members_q[k_q];
          out_res_d.no_cover     = nocov_q;
          out_res_d.last_member  = last_emit;
          if (last_emit) begin
            state_d = msc_pkg::ST_IDLE;
          end else begin
            k_d = k_q - KW'(1);
          end
        end
      end

      default: begin
        state_d = msc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/msc_checker.sv -----
// ----------------------------------------------------------------------------
// Minimum set cover port checker
// Watches the top level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input msc_pkg::in_req_t              in_req_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input msc_pkg::out_res_t             out_res_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [msc_pkg::SkillCntW-1:0] cfg_data_i
);

  logic in_take;
  logic out_hold;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;

  // Hold a stalled result
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
              out_hold |=> out_valid_o && $stable(out_res_o), "stalled result changed")

  // A missing cover is a single final result with index zero
  `ASSERT_CLK(a_nocov_form, clk_i, rst_ni,
              out_valid_o && out_res_o.no_cover |->
              out_res_o.last_member && (out_res_o.member_index == '0),
              "malformed no-cover result")

  // The final candidate starts the search: no request is taken next cycle
  `ASSERT_CLK(a_search_busy, clk_i, rst_ni,
              in_take && in_req_i.last_candidate |=> in_stall_o,
              "request taken right after last candidate")

  // While a team is still being handed out no request is taken
  `ASSERT_CLK(a_team_busy, clk_i, rst_ni,
              out_valid_o && !out_res_o.last_member |-> in_stall_o,
              "request taken during team output")

  // The register port never pushes back and carries known data
  `ASSERT_ALWAYS(a_cfg_ready, clk_i,
                 !rst_ni || !cfg_valid_i || (cfg_ready_o && !$isunknown(cfg_data_i)),
                 "configuration write refused or unknown")

endmodule

bind minimum_set_cover_bitmask msc_checker u_msc_checker (.*);
